FILE: design/mnvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnvs_pkg
// Shared constants, codes and types of the masked nearest vector search.
// ----------------------------------------------------------------------------
package mnvs_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_REFS  = 1024;

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int REF_W  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int NCNT_W = $clog2(MAX_NODES + 1);
    localparam int RCNT_W = $clog2(MAX_REFS + 1);

    localparam int KIND_W     = 2;
    localparam int IN_REF_W   = 10;
    localparam int IN_NODE_W  = 6;
    localparam int ELEM_W     = 32;
    localparam int DIST_W     = 63;
    localparam int SQ_W       = 64;
    localparam int NIU_W      = 7;
    localparam int RC_W       = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int DRAIN_CYCLES = 3;
    localparam int DRAIN_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFS  = 2'd1;

    localparam logic [DIST_W-1:0] SAT_MAX = {DIST_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_REF,
        KIND_QUERY,
        KIND_MASK,
        KIND_SEARCH
    } kind_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DRAIN,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic             vld;
        logic             en;
        logic             first;
        logic             last;
        logic [REF_W-1:0] row;
    } tag_t;

    typedef struct packed {
        logic              found;
        logic [REF_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
    } best_t;

endpackage

FILE: design/masked_nearest_vector_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_nearest_vector_search
// Nearest reference vector to a query by masked squared Euclidean distance.
// ----------------------------------------------------------------------------
// Load transactions (reference element, query element, mask bit) are taken
// one per cycle while no search is running, also while a search result
// waits at the output. A search transaction reads one reference element per
// cycle from the reference memory's single read port, walking
// reference_count * max(nodes_in_use, 1) elements, then drains the read,
// difference and square pipeline before its result appears; a new
// search is accepted once the previous result has been taken. The stores
// have no reset clearing; reference and query elements must be written
// before a search uses them, and the mask resets to all disabled.
module masked_nearest_vector_search (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mnvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mnvs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mnvs_pkg::KIND_W-1:0]     kind,
    input  logic [mnvs_pkg::IN_REF_W-1:0]   ref_index,
    input  logic [mnvs_pkg::IN_NODE_W-1:0]  node_index,
    input  logic signed [mnvs_pkg::ELEM_W-1:0] value,
    input  logic                            enable_bit,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [mnvs_pkg::IN_REF_W-1:0]   closest_index,
    output logic [mnvs_pkg::DIST_W-1:0]     min_distance
);
    import mnvs_pkg::*;

    logic [NCNT_W-1:0]     niu_reg;
    logic [RCNT_W-1:0]     rc_reg;
    logic [MAX_NODES-1:0]  mask_reg;
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [IN_REF_W-1:0]   idx_reg;
    logic [DIST_W-1:0]     dist_reg;

    logic                  accept;
    logic                  start;
    logic                  node_ok;
    logic                  ref_ok;
    logic                  ref_we;
    logic                  qry_we;
    logic                  busy;
    logic                  done;
    logic                  clear;
    logic [REF_W-1:0]      rd_row;
    logic [NODE_W-1:0]     rd_node;
    logic [ELEM_W-1:0]     ref_rdata;
    logic [ELEM_W-1:0]     qry_rdata;
    logic [SQ_W-1:0]       sq;
    tag_t                  issue_tag;
    tag_t                  sq_tag;
    best_t                 best;
    logic [NIU_W-1:0]      niu_raw;
    logic [RC_W-1:0]       rc_raw;

    assign in_ready = !busy && !((kind == KIND_SEARCH) && out_valid_reg);
    assign accept   = in_valid && in_ready;
    assign start    = accept && (kind == KIND_SEARCH);
    assign node_ok  = (32'(node_index) < MAX_NODES);
    assign ref_ok   = (32'(ref_index) < MAX_REFS);
    assign ref_we   = accept && (kind == KIND_REF) && node_ok && ref_ok;
    assign qry_we   = accept && (kind == KIND_QUERY) && node_ok;

    assign niu_raw = cfg_data[NIU_W-1:0];
    assign rc_raw  = cfg_data[RC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            niu_reg <= '0;
            rc_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NODES)
            begin
                niu_reg <= (32'(niu_raw) > MAX_NODES) ? NCNT_W'(MAX_NODES) : NCNT_W'(niu_raw);
            end
            else if (cfg_index == CFG_REFS)
            begin
                rc_reg <= (32'(rc_raw) > MAX_REFS) ? RCNT_W'(MAX_REFS) : RCNT_W'(rc_raw);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (accept && (kind == KIND_MASK) && node_ok)
        begin
            mask_reg[NODE_W'(node_index)] <= enable_bit;
        end
    end

    mnvs_ram #(
        .DEPTH (2 ** (REF_W + NODE_W)),
        .WIDTH (ELEM_W)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr ({REF_W'(ref_index), NODE_W'(node_index)}),
        .wdata (value),
        .raddr ({rd_row, rd_node}),
        .rdata (ref_rdata)
    );

    mnvs_ram #(
        .DEPTH (2 ** NODE_W),
        .WIDTH (ELEM_W)
    ) u_qry_ram (
        .clk   (clk),
        .we    (qry_we),
        .waddr (NODE_W'(node_index)),
        .wdata (value),
        .raddr (rd_node),
        .rdata (qry_rdata)
    );

    mnvs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .niu   (niu_reg),
        .rc    (rc_reg),
        .mask  (mask_reg),
        .row   (rd_row),
        .node  (rd_node),
        .tag   (issue_tag),
        .clear (clear),
        .busy  (busy),
        .done  (done)
    );

    mnvs_sqdiff u_sqdiff (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (issue_tag),
        .qdata   (qry_rdata),
        .rdata   (ref_rdata),
        .tag_out (sq_tag),
        .sq      (sq)
    );

    mnvs_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (clear),
        .tag   (sq_tag),
        .sq    (sq),
        .best  (best)
    );

    // Hold the result until its transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            found_reg <= best.found;
            idx_reg   <= best.found ? IN_REF_W'(best.idx) : '0;
            dist_reg  <= best.found ? best.distance : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign closest_index = idx_reg;
    assign min_distance  = dist_reg;

endmodule

FILE: design/mnvs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnvs_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mnvs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mnvs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnvs_seq
// Search sequencer: walks reference rows and nodes, issues memory reads and
// element tags, then drains the datapath and signals completion.
// ----------------------------------------------------------------------------
module mnvs_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mnvs_pkg::NCNT_W-1:0] niu,
    input  logic [mnvs_pkg::RCNT_W-1:0] rc,
    input  logic [mnvs_pkg::MAX_NODES-1:0] mask,
    output logic [mnvs_pkg::REF_W-1:0]  row,
    output logic [mnvs_pkg::NODE_W-1:0] node,
    output mnvs_pkg::tag_t              tag,
    output logic                        clear,
    output logic                        busy,
    output logic                        done
);
    import mnvs_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [REF_W-1:0]    row_reg, row_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [DRAIN_W-1:0]  drain_reg, drain_next;
    logic [NCNT_W-1:0]   last_n;
    logic                last_node;
    logic                last_row;

    assign last_n    = (niu == '0) ? '0 : niu - 1'b1;
    assign last_node = (NCNT_W'(node_reg) == last_n);
    assign last_row  = (RCNT_W'(row_reg) == rc - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            row_reg   <= '0;
            node_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            node_reg  <= node_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        node_next  = node_reg;
        drain_next = drain_reg;
        tag        = '0;
        clear      = 1'b0;
        done       = 1'b0;
        busy       = 1'b1;
        case (state_reg)
            SEQ_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    clear      = 1'b1;
                    row_next   = '0;
                    node_next  = '0;
                    drain_next = '0;
                    state_next = (rc == '0) ? SEQ_DRAIN : SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                tag.vld   = 1'b1;
                tag.en    = (NCNT_W'(node_reg) < niu) && mask[node_reg];
                tag.first = (node_reg == '0);
                tag.last  = last_node;
                tag.row   = row_reg;
                if (last_node)
                begin
                    node_next = '0;
                    if (last_row)
                    begin
                        state_next = SEQ_DRAIN;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    node_next = node_reg + 1'b1;
                end
            end
            SEQ_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1))
                begin
                    state_next = SEQ_DONE;
                end
            end
            SEQ_DONE:
            begin
                done       = 1'b1;
                state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign row  = row_reg;
    assign node = node_reg;

endmodule

FILE: design/mnvs_sqdiff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnvs_sqdiff
// Two-stage squared difference of a query and a reference element.
// ----------------------------------------------------------------------------
module mnvs_sqdiff (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mnvs_pkg::tag_t              tag_in,
    input  logic [mnvs_pkg::ELEM_W-1:0] qdata,
    input  logic [mnvs_pkg::ELEM_W-1:0] rdata,
    output mnvs_pkg::tag_t              tag_out,
    output logic [mnvs_pkg::SQ_W-1:0]   sq
);
    import mnvs_pkg::*;

    tag_t               tag_s1_reg, tag_s2_reg, tag_s3_reg;
    logic [ELEM_W-1:0]  mag_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic signed [ELEM_W:0] diff;
    logic [ELEM_W:0]    mag;

    assign diff = $signed({qdata[ELEM_W-1], qdata}) - $signed({rdata[ELEM_W-1], rdata});
    assign mag  = diff[ELEM_W] ? (~diff + 1'b1) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s1_reg <= '0;
            tag_s2_reg <= '0;
            tag_s3_reg <= '0;
        end
        else
        begin
            tag_s1_reg <= tag_in;
            tag_s2_reg <= tag_s1_reg;
            tag_s3_reg <= tag_s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag[ELEM_W-1:0];
        sq_reg  <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
    end

    assign tag_out = tag_s3_reg;
    assign sq      = sq_reg;

endmodule

FILE: design/mnvs_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnvs_accum
// Saturating distance accumulator and running best-candidate tracker.
// ----------------------------------------------------------------------------
module mnvs_accum (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  mnvs_pkg::tag_t            tag,
    input  logic [mnvs_pkg::SQ_W-1:0] sq,
    output mnvs_pkg::best_t           best
);
    import mnvs_pkg::*;

    logic [DIST_W-1:0] acc_reg;
    best_t             best_reg;
    logic [DIST_W-1:0] term;
    logic [DIST_W-1:0] base;
    logic [SQ_W-1:0]   sum;
    logic [DIST_W-1:0] total;

    assign term  = !tag.en ? '0 : (sq[SQ_W-1] ? SAT_MAX : sq[DIST_W-1:0]);
    assign base  = tag.first ? '0 : acc_reg;
    assign sum   = SQ_W'(base) + SQ_W'(term);
    assign total = sum[SQ_W-1] ? SAT_MAX : sum[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (tag.vld)
        begin
            acc_reg <= total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg.found    <= 1'b0;
            best_reg.idx      <= '0;
            best_reg.distance <= SAT_MAX;
        end
        else if (clear)
        begin
            best_reg.found    <= 1'b0;
            best_reg.idx      <= '0;
            best_reg.distance <= SAT_MAX;
        end
        else if (tag.vld && tag.last && (total < best_reg.distance))
        begin
            best_reg.found    <= 1'b1;
            best_reg.idx      <= tag.row;
            best_reg.distance <= total;
        end
    end

    assign best = best_reg;

endmodule

FILE: design/mnvs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnvs_checker
// Port-level assertions for the masked nearest vector search.
// ----------------------------------------------------------------------------
module mnvs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [mnvs_pkg::KIND_W-1:0]     kind,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            found,
    input  logic [mnvs_pkg::IN_REF_W-1:0]   closest_index,
    input  logic [mnvs_pkg::DIST_W-1:0]     min_distance
);
    import mnvs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found)
            && $stable(closest_index) && $stable(min_distance))
        else $error("result changed while stalled");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (closest_index == '0) && (min_distance == '0))
        else $error("empty result carries nonzero fields");

    a_found_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (min_distance != SAT_MAX))
        else $error("found result at saturation maximum");

    a_no_search_on_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_valid && in_ready |-> (kind != KIND_SEARCH))
        else $error("search accepted while a result is pending");

endmodule

bind masked_nearest_vector_search mnvs_checker u_mnvs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .closest_index (closest_index),
    .min_distance  (min_distance)
);
